/* rtl/hsd_pkg.sv */
// Shared types and constants of the Huffman stream decoder.
`default_nettype none
package hsd_pkg;
  localparam int TABLE_DEPTH  = 4096;
  localparam int MAX_CODE_LEN = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = IDX_W + 1;
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int CFG_W        = 13;
  localparam logic [7:0] LEAD_MAX_SINGLE = 8'd127;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_FINAL = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] entry_index;
    logic [7:0]  sym_lead;
    logic [7:0]  sym_trail;
    logic [4:0]  code_len;
    logic [15:0] code_value;
    logic [7:0]  data_byte;
    logic [2:0]  final_last_bit;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow_error;
    logic       last;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0]  lead;
    logic [7:0]  trail;
    logic [4:0]  code_len;
    logic [15:0] code_value;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_FINAL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [11:0] index;
    entry_t      entry;
    logic [7:0]  data_byte;
    logic [3:0]  nbits;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_RD,
    ST_CMP,
    ST_TRAIL,
    ST_STEP,
    ST_FLUSH
  } bst_t;
endpackage
`default_nettype wire

/* rtl/hsd_front.sv */
// Front end: classifies requests and queues them for the back end.
`default_nettype none
module hsd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hsd_pkg::in_req_t   req,
  input  wire logic               pop,
  output logic                    full,
  output hsd_pkg::head_t          head
);
  hsd_pkg::cmd_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  hsd_pkg::cmd_t cmd;
  logic          keep;
  logic [4:0]    len;
  logic [15:0]   mask;

  always_comb begin
    len  = (req.code_len > 5'(hsd_pkg::MAX_CODE_LEN)) ? 5'(hsd_pkg::MAX_CODE_LEN)
                                                         : req.code_len;
    mask = 16'((17'd1 << len) - 17'd1);
    cmd = '0;
    cmd.index            = req.entry_index;
    cmd.entry.lead       = req.sym_lead;
    cmd.entry.trail      = req.sym_trail;
    cmd.entry.code_len   = len;
    cmd.entry.code_value = req.code_value & mask;
    cmd.data_byte        = req.data_byte;
    keep = 1'b1;
    unique case (hsd_pkg::mode_t'(req.mode))
      hsd_pkg::MODE_WRITE: begin
        cmd.kind  = hsd_pkg::CMD_WRITE;
        cmd.nbits = 4'd0;
      end
      hsd_pkg::MODE_DATA: begin
        cmd.kind  = hsd_pkg::CMD_DATA;
        cmd.nbits = 4'd8;
      end
      hsd_pkg::MODE_FINAL: begin
        cmd.kind  = hsd_pkg::CMD_FINAL;
        cmd.nbits = {1'b0, req.final_last_bit} + 4'd1;
      end
      default: begin
        cmd.kind  = hsd_pkg::CMD_WRITE;
        cmd.nbits = 4'd0;
        keep      = 1'b0;
      end
    endcase
  end

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && keep) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && keep) q_r[wp_r] <= cmd;
  end
endmodule
`default_nettype wire

/* rtl/hsd_back.sv */
// Back end: code table, bitwise accumulation and binary table search.
`default_nettype none
module hsd_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [hsd_pkg::CNT_W-1:0]  n_entries,
  input  wire hsd_pkg::head_t             head,
  output logic                            pop,
  output logic                            out_valid,
  output hsd_pkg::out_rsp_t               out_rsp
);
  hsd_pkg::entry_t mem [hsd_pkg::TABLE_DEPTH];
  hsd_pkg::entry_t rdata_r;
  logic [hsd_pkg::IDX_W-1:0] raddr;

  hsd_pkg::bst_t st_r, st_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [hsd_pkg::LEN_W-1:0] alen_r, alen_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  left_r, left_nxt;
  logic        fin_r, fin_nxt;
  logic [hsd_pkg::CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [hsd_pkg::CNT_W:0]   sum;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        pv_r, pv_nxt;
  logic [8:0]  pend_r, pend_nxt;
  logic        emit;
  logic [8:0]  emit_d;
  logic        mem_we;
  logic [4:0]  m, el;
  logic [15:0] ep, ap;
  logic        lt, gt;

  always_comb begin
    el = rdata_r.code_len;
    m  = (el < alen_r) ? el : alen_r;
    ep = rdata_r.code_value >> (el - m);
    ap = acc_r >> (alen_r - m);
    lt = 1'b0;
    gt = 1'b0;
    if (m != 5'd0 && ep != ap) begin
      lt = ep < ap;
      gt = ep > ap;
    end else begin
      lt = el < alen_r;
      gt = el > alen_r;
    end
  end

  assign sum   = {1'b0, lo_r} + {1'b0, hi_r} - 1'b1;
  // probe address goes to the table in the cycle the midpoint is formed
  assign raddr = mid_nxt[hsd_pkg::IDX_W-1:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hsd_pkg::ST_IDLE: if (head.valid) begin
        st_nxt = (head.cmd.kind == hsd_pkg::CMD_WRITE) ? hsd_pkg::ST_IDLE : hsd_pkg::ST_BIT;
      end
      hsd_pkg::ST_BIT:   st_nxt = hsd_pkg::ST_RD;
      hsd_pkg::ST_RD:    st_nxt = (lo_r < hi_r) ? hsd_pkg::ST_CMP : hsd_pkg::ST_STEP;
      hsd_pkg::ST_CMP: begin
        if (!lt && !gt) begin
          st_nxt = (rdata_r.lead > hsd_pkg::LEAD_MAX_SINGLE) ? hsd_pkg::ST_TRAIL
                                                              : hsd_pkg::ST_STEP;
        end else begin
          st_nxt = hsd_pkg::ST_RD;
        end
      end
      hsd_pkg::ST_TRAIL: st_nxt = hsd_pkg::ST_STEP;
      hsd_pkg::ST_STEP:  st_nxt = (left_r != 4'd0) ? hsd_pkg::ST_BIT : hsd_pkg::ST_FLUSH;
      hsd_pkg::ST_FLUSH: st_nxt = hsd_pkg::ST_IDLE;
      default:           st_nxt = hsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    emit     = 1'b0;
    emit_d   = '0;
    acc_nxt  = acc_r;
    alen_nxt = alen_r;
    byte_nxt = byte_r;
    left_nxt = left_r;
    fin_nxt  = fin_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    cnt_nxt  = cnt_r;
    pv_nxt   = pv_r;
    pend_nxt = pend_r;
    out_valid = 1'b0;
    out_rsp   = '0;
    unique case (st_r)
      hsd_pkg::ST_IDLE: if (head.valid) begin
        pop      = 1'b1;
        mem_we   = (head.cmd.kind == hsd_pkg::CMD_WRITE);
        byte_nxt = head.cmd.data_byte;
        left_nxt = head.cmd.nbits;
        fin_nxt  = (head.cmd.kind == hsd_pkg::CMD_FINAL);
        cnt_nxt  = 5'd0;
      end
      hsd_pkg::ST_BIT: begin
        if (alen_r == hsd_pkg::LEN_W'(hsd_pkg::MAX_CODE_LEN)) begin
          emit     = 1'b1;
          emit_d   = {8'd0, 1'b1};
          acc_nxt  = {15'd0, byte_r[7]};
          alen_nxt = hsd_pkg::LEN_W'(1);
        end else begin
          acc_nxt  = {acc_r[14:0], byte_r[7]};
          alen_nxt = alen_r + 1'b1;
        end
        byte_nxt = {byte_r[6:0], 1'b0};
        left_nxt = left_r - 4'd1;
        lo_nxt   = '0;
        hi_nxt   = n_entries;
      end
      hsd_pkg::ST_RD: mid_nxt = sum[hsd_pkg::CNT_W:1];
      hsd_pkg::ST_CMP: begin
        if (lt)      lo_nxt = mid_r + 1'b1;
        else if (gt) hi_nxt = mid_r;
        else begin
          emit     = 1'b1;
          emit_d   = {rdata_r.lead, 1'b0};
          acc_nxt  = '0;
          alen_nxt = '0;
        end
      end
      hsd_pkg::ST_TRAIL: begin
        emit   = 1'b1;
        emit_d = {rdata_r.trail, 1'b0};
      end
      hsd_pkg::ST_STEP: if (left_r == 4'd0 && fin_r) begin
        acc_nxt  = '0;
        alen_nxt = '0;
      end
      hsd_pkg::ST_FLUSH: begin
        out_valid = pv_r;
        out_rsp   = {pend_r, 1'b1};
        pv_nxt    = 1'b0;
      end
      default: ;
    endcase
    if (emit && cnt_r < 5'(hsd_pkg::MAX_RESULTS)) begin
      out_valid = pv_r;
      out_rsp   = {pend_r, 1'b0};
      pend_nxt  = emit_d;
      pv_nxt    = 1'b1;
      cnt_nxt   = cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= hsd_pkg::ST_IDLE;
      acc_r  <= '0;
      alen_r <= '0;
      left_r <= '0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      acc_r  <= acc_nxt;
      alen_r <= alen_nxt;
      left_r <= left_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
      pv_r   <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[head.cmd.index] <= head.cmd.entry;
    rdata_r <= mem[raddr];
  end

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    alen_r <= hsd_pkg::LEN_W'(hsd_pkg::MAX_CODE_LEN))
    else $error("accumulator length beyond maximum");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(hsd_pkg::MAX_RESULTS))
    else $error("result count beyond limit");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.overflow_error |-> out_rsp.out_byte == 8'd0)
    else $error("error result with nonzero byte");
  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == hsd_pkg::ST_FLUSH |=> !pv_r)
    else $error("pending result left after flush");
endmodule
`default_nettype wire

/* rtl/huffman_stream_decoder_core.sv */
// Top level of the Huffman stream decoder: config register, front and back ends.
// Sequence: a table write is queued and written when the idle back end takes it from the queue;
// a data byte is shifted in bit by bit, and each bit starts a binary table search (up to 13
// probes at 4096 entries) through the single table read port.
// Throughput: one request at a time in the search; a two-entry queue absorbs new requests.
// Each result is held one stage and leaves with the next result or at the end of its request.
// Synchronous active-low reset clears accumulator, queue and entry count; table is not cleared.
`default_nettype none
module huffman_stream_decoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire hsd_pkg::in_req_t           in_req,
  output logic                            out_valid,
  output hsd_pkg::out_rsp_t               out_rsp,
  input  wire logic                       cfg_we,
  input  wire logic [hsd_pkg::CFG_W-1:0]  cfg_wdata
);
  logic [hsd_pkg::CFG_W-1:0] entries_r;
  logic [hsd_pkg::CNT_W-1:0] n_entries;
  hsd_pkg::head_t head;
  logic pop;

  always_ff @(posedge clk) begin
    if (!rst_n)      entries_r <= '0;
    else if (cfg_we) entries_r <= cfg_wdata;
  end

  assign n_entries = (entries_r > hsd_pkg::CFG_W'(hsd_pkg::TABLE_DEPTH)) ?
                     hsd_pkg::CNT_W'(hsd_pkg::TABLE_DEPTH) : hsd_pkg::CNT_W'(entries_r);

  hsd_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .push (start && !busy),
    .req  (in_req),
    .pop  (pop),
    .full (busy),
    .head (head)
  );

  hsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .n_entries(n_entries),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );
endmodule
`default_nettype wire
